// File: hw/rtl/r12uc_pkg.sv
// ----------------------------------------------------------------------------
// r12uc_pkg: shared types and constants of the RAW12 unpack and crop block
// Item types for both channels, configuration record, register indexes and
// counter limits.
// ----------------------------------------------------------------------------
package r12uc_pkg;

  // Configuration register indexes
  localparam logic [2:0] RegLineBytes    = 3'd0;
  localparam logic [2:0] RegWindowLeft   = 3'd1;
  localparam logic [2:0] RegWindowTop    = 3'd2;
  localparam logic [2:0] RegWindowWidth  = 3'd3;
  localparam logic [2:0] RegWindowHeight = 3'd4;

  // Register reset values
  localparam logic [13:0] LineBytesReset    = 14'd6112;
  localparam logic [12:0] WindowLeftReset   = 13'd0;
  localparam logic [12:0] WindowTopReset    = 13'd0;
  localparam logic [12:0] WindowWidthReset  = 13'd4056;
  localparam logic [12:0] WindowHeightReset = 13'd3040;

  // Counter limits
  localparam logic [13:0] LineMax = 14'd16383;
  localparam logic [12:0] RowMax  = 13'd8191;
  localparam logic [12:0] ColMax  = 13'd8191;

  // Byte position within a pixel pair
  localparam logic [1:0] PhaseHighEven = 2'd0;
  localparam logic [1:0] PhaseHighOdd  = 2'd1;
  localparam logic [1:0] PhaseLowBits  = 2'd2;

  // Incoming byte item
  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } byte_t;

  // Outgoing pixel pair item
  typedef struct packed {
    logic [15:0] pixel_even;
    logic [15:0] pixel_odd;
    logic [12:0] out_column;
    logic [12:0] out_row;
  } pair_t;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic [13:0] line_bytes;
    logic [12:0] window_left;
    logic [12:0] window_top;
    logic [12:0] window_width;
    logic [12:0] window_height;
  } cfg_t;

endpackage

// File: hw/rtl/r12uc_unpack.sv
// ----------------------------------------------------------------------------
// r12uc_unpack: byte position tracking, crop test and pair assembly
// Holds the line and window counters and the held high bytes. On every
// taken byte it updates them and offers at most one finished pixel pair.
// ----------------------------------------------------------------------------
module r12uc_unpack (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  r12uc_pkg::byte_t  item,
  input  r12uc_pkg::cfg_t   cfg,
  output logic              emit,
  output r12uc_pkg::pair_t  pair
);

  logic [13:0] byte_column;
  logic [13:0] line_count;
  logic [12:0] pixel_column;
  logic [12:0] pixel_row;
  logic [1:0]  byte_phase;
  logic [7:0]  held_high_even;
  logic [7:0]  held_high_odd;

  logic [13:0] byte_column_next;
  logic [13:0] line_count_next;
  logic [12:0] pixel_column_next;
  logic [12:0] pixel_row_next;
  logic [1:0]  byte_phase_next;
  logic [7:0]  held_high_even_next;
  logic [7:0]  held_high_odd_next;

  // State after an optional frame start clear
  logic [13:0] bc0;
  logic [13:0] lc0;
  logic [12:0] pc0;
  logic [12:0] pr0;
  logic [1:0]  ph0;
  logic [7:0]  he0;
  logic [7:0]  ho0;

  // State after the new line step
  logic        new_line;
  logic [13:0] bc1;
  logic [13:0] lc1;
  logic [12:0] pc1;
  logic [12:0] pr1;
  logic [1:0]  ph1;

  logic [13:0] start_byte;
  logic        in_window;
  logic [13:0] col_sum;

  // Window start byte: pair index times three
  assign start_byte = {2'b00, cfg.window_left[12:1]} + {1'b0, cfg.window_left[12:1], 1'b0};

  always_comb begin
    // Clear on frame start
    bc0 = item.frame_start ? '0 : byte_column;
    lc0 = item.frame_start ? '0 : line_count;
    pc0 = item.frame_start ? '0 : pixel_column;
    pr0 = item.frame_start ? '0 : pixel_row;
    ph0 = item.frame_start ? '0 : byte_phase;
    he0 = item.frame_start ? '0 : held_high_even;
    ho0 = item.frame_start ? '0 : held_high_odd;

    // Start a new line once the padded length is used up
    new_line = (bc0 >= cfg.line_bytes);
    bc1 = new_line ? '0 : bc0;
    pc1 = new_line ? '0 : pc0;
    ph1 = new_line ? '0 : ph0;
    lc1 = (new_line && lc0 != r12uc_pkg::LineMax) ? lc0 + 14'd1 : lc0;
    pr1 = (new_line && lc1 > {1'b0, cfg.window_top} && pr0 != r12uc_pkg::RowMax)
          ? pr0 + 13'd1 : pr0;

    in_window = (bc1 >= start_byte) && (lc1 >= {1'b0, cfg.window_top}) &&
                (pc1 < cfg.window_width) && (pr1 < cfg.window_height);

    col_sum = {1'b0, pc1} + 14'd2;

    byte_column_next    = bc1 + 14'd1;
    line_count_next     = lc1;
    pixel_column_next   = pc1;
    pixel_row_next      = pr1;
    byte_phase_next     = ph1;
    held_high_even_next = he0;
    held_high_odd_next  = ho0;
    emit                = 1'b0;

    pair.pixel_even = {he0, item.data_byte[3:0], 4'h0};
    pair.pixel_odd  = {ho0, item.data_byte[7:4], 4'h0};
    pair.out_column = pc1;
    pair.out_row    = pr1;

    // Advance the pair phase for bytes inside the window
    if (in_window) begin
      case (ph1)
        r12uc_pkg::PhaseHighOdd: begin
          held_high_odd_next = item.data_byte;
          byte_phase_next    = r12uc_pkg::PhaseLowBits;
        end
        r12uc_pkg::PhaseLowBits: begin
          emit              = 1'b1;
          pixel_column_next = (col_sum > {1'b0, r12uc_pkg::ColMax})
                              ? r12uc_pkg::ColMax : col_sum[12:0];
          byte_phase_next   = r12uc_pkg::PhaseHighEven;
        end
        default: begin
          held_high_even_next = item.data_byte;
          byte_phase_next     = r12uc_pkg::PhaseHighOdd;
        end
      endcase
    end
  end

  // Update state on every taken byte
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_column    <= '0;
      line_count     <= '0;
      pixel_column   <= '0;
      pixel_row      <= '0;
      byte_phase     <= '0;
      held_high_even <= '0;
      held_high_odd  <= '0;
    end else if (take) begin
      byte_column    <= byte_column_next;
      line_count     <= line_count_next;
      pixel_column   <= pixel_column_next;
      pixel_row      <= pixel_row_next;
      byte_phase     <= byte_phase_next;
      held_high_even <= held_high_even_next;
      held_high_odd  <= held_high_odd_next;
    end
  end

endmodule

// File: hw/rtl/raw12_packed_unpack_crop.sv
// ----------------------------------------------------------------------------
// raw12_packed_unpack_crop: packed RAW12 byte stream to cropped pixel pairs
//
//   channel  | direction | handshake                 | item
//   ---------+-----------+---------------------------+---------------------
//   byte     | in        | byte_valid / byte_stall   | r12uc_pkg::byte_t
//   pair     | out       | pair_valid / pair_stall   | r12uc_pkg::pair_t
//   cfg      | in        | cfg_we (no handshake back)| cfg_index, cfg_data
//
// One byte item is taken per clock while byte_stall is low. A pair is
// offered from the result register in the cycle after its third byte is
// taken; the single result register sets the rate. byte_stall rises only
// while a pair is held under pair_stall. Synchronous reset clears counters,
// held bytes and the result valid, and loads the register defaults.
// ----------------------------------------------------------------------------
module raw12_packed_unpack_crop (
  input  logic              clk,
  input  logic              rst,
  input  logic              byte_valid,
  output logic              byte_stall,
  input  r12uc_pkg::byte_t  byte_item,
  output logic              pair_valid,
  input  logic              pair_stall,
  output r12uc_pkg::pair_t  pair_item,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [13:0]       cfg_data
);

  r12uc_pkg::cfg_t  cfg;
  r12uc_pkg::pair_t pair;
  logic             take;
  logic             emit;

  // Take a byte whenever the result register is free or being emptied
  assign byte_stall = pair_valid && pair_stall;
  assign take       = byte_valid && !byte_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.line_bytes    <= r12uc_pkg::LineBytesReset;
      cfg.window_left   <= r12uc_pkg::WindowLeftReset;
      cfg.window_top    <= r12uc_pkg::WindowTopReset;
      cfg.window_width  <= r12uc_pkg::WindowWidthReset;
      cfg.window_height <= r12uc_pkg::WindowHeightReset;
    end else if (cfg_we) begin
      case (cfg_index)
        r12uc_pkg::RegLineBytes:    cfg.line_bytes    <= cfg_data;
        r12uc_pkg::RegWindowLeft:   cfg.window_left   <= cfg_data[12:0];
        r12uc_pkg::RegWindowTop:    cfg.window_top    <= cfg_data[12:0];
        r12uc_pkg::RegWindowWidth:  cfg.window_width  <= cfg_data[12:0];
        r12uc_pkg::RegWindowHeight: cfg.window_height <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  r12uc_unpack u_unpack (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .item (byte_item),
    .cfg  (cfg),
    .emit (emit),
    .pair (pair)
  );

  // Result register: load on a taken byte, drop once the pair is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      pair_valid <= 1'b0;
    end else if (take) begin
      pair_valid <= emit;
    end else if (!pair_stall) begin
      pair_valid <= 1'b0;
    end
  end

  // Hold the pair payload
  always_ff @(posedge clk) begin
    if (take && emit) begin
      pair_item <= pair;
    end
  end

endmodule
